### rtl/ffva_pkg.sv
// Shared types and constants for the first-fit allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffva_pkg;
  localparam int HEAP_DEPTH = 1024;
  localparam int WORD_BYTES = 8;
  localparam int ADDR_W = $clog2(HEAP_DEPTH);
  localparam int SIZE_W = $clog2(HEAP_DEPTH + 1);
  localparam int HDR_W = SIZE_W + 1;
  localparam int WB_SHIFT = $clog2(WORD_BYTES);
  localparam int CFG_W = 11;
  localparam int REQ_W = 2;
  localparam int BYTES_W = 14;
  localparam int OFF_W = 13;
  localparam int ST_W = 2;
  localparam int NEED_W = BYTES_W + 1 - WB_SHIFT;
  localparam int LIM_W = NEED_W + 1;
  localparam int HEAD_W = OFF_W - WB_SHIFT;

  typedef enum logic [REQ_W-1:0] {REQ_ALLOC, REQ_FREE, REQ_LARGEST, REQ_REINIT} req_t;
  typedef enum logic [ST_W-1:0] {ST_OK, ST_NO_SPACE, ST_IGNORED} status_t;
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_LOOP, S_EVCUR, S_WRSPLIT, S_WRCUR, S_EVNXT, S_REINIT, S_EMIT
  } state_t;
  typedef enum logic [2:0] {
    WR_NONE, WR_INIT, WR_CFG, WR_SPLIT, WR_TAKE, WR_ALLOC, WR_FREE, WR_MERGE
  } wr_t;
  typedef enum logic [1:0] {CUR_HOLD, CUR_ADD_RD, CUR_ADD_SZ} cur_t;
  typedef enum logic [1:0] {BEST_HOLD, BEST_RD, BEST_SZ} best_t;

  typedef struct packed {
    logic    load;
    logic    cfg;
    logic    cap;
    logic    rd_nxt;
    wr_t     wr;
    cur_t    cur;
    best_t   best;
    logic    set_st;
    status_t st;
    logic    set_off;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    req_t op;
    logic go;
    logic at_head;
    logic past_head;
    logic rd_tk;
    logic rd_zero;
    logic rd_over;
    logic fit;
    logic split;
    logic nxt_end;
  } stat_t;
endpackage
`default_nettype wire

### rtl/ffva_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ffva_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/ffva_ctrl.sv
// Controller state machine sequencing header walks.
`timescale 1ns / 1ps
`default_nettype none
module ffva_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire ffva_pkg::req_t  req,
  input  wire logic            cfg_we,
  input  wire ffva_pkg::stat_t stat,
  output ffva_pkg::cmd_t       cmd,
  output logic                 busy
);
  ffva_pkg::state_t state_r, state_nxt;

  function automatic ffva_pkg::status_t fail_st(input ffva_pkg::req_t op);
    ffva_pkg::status_t s;
    case (op)
      ffva_pkg::REQ_ALLOC: s = ffva_pkg::ST_NO_SPACE;
      ffva_pkg::REQ_FREE:  s = ffva_pkg::ST_IGNORED;
      default:             s = ffva_pkg::ST_OK;
    endcase
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffva_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffva_pkg::S_INIT:    state_nxt = ffva_pkg::S_IDLE;
      ffva_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (req == ffva_pkg::REQ_REINIT) ? ffva_pkg::S_REINIT : ffva_pkg::S_LOOP;
        end
      end
      ffva_pkg::S_REINIT:  state_nxt = ffva_pkg::S_EMIT;
      ffva_pkg::S_LOOP:    state_nxt = stat.go ? ffva_pkg::S_EVCUR : ffva_pkg::S_EMIT;
      ffva_pkg::S_EVCUR: begin
        if (stat.op == ffva_pkg::REQ_FREE) begin
          if (stat.at_head || stat.rd_zero || stat.past_head) begin
            state_nxt = ffva_pkg::S_EMIT;
          end else begin
            state_nxt = ffva_pkg::S_LOOP;
          end
        end else if (stat.rd_zero || stat.rd_over) begin
          state_nxt = ffva_pkg::S_EMIT;
        end else if (stat.rd_tk) begin
          state_nxt = ffva_pkg::S_LOOP;
        end else if (stat.op == ffva_pkg::REQ_ALLOC && stat.fit) begin
          state_nxt = stat.split ? ffva_pkg::S_WRSPLIT : ffva_pkg::S_EMIT;
        end else if (stat.nxt_end) begin
          state_nxt = (stat.op == ffva_pkg::REQ_ALLOC) ? ffva_pkg::S_EMIT : ffva_pkg::S_LOOP;
        end else begin
          state_nxt = ffva_pkg::S_EVNXT;
        end
      end
      ffva_pkg::S_WRSPLIT: state_nxt = ffva_pkg::S_WRCUR;
      ffva_pkg::S_WRCUR:   state_nxt = ffva_pkg::S_EMIT;
      ffva_pkg::S_EVNXT:   state_nxt = ffva_pkg::S_LOOP;
      ffva_pkg::S_EMIT:    state_nxt = ffva_pkg::S_IDLE;
      default:             state_nxt = ffva_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ffva_pkg::S_INIT: cmd.wr = ffva_pkg::WR_INIT;
      ffva_pkg::S_IDLE: begin
        cmd.load = start;
        cmd.cfg  = cfg_we;
        cmd.wr   = cfg_we ? ffva_pkg::WR_CFG : ffva_pkg::WR_NONE;
      end
      ffva_pkg::S_REINIT: begin
        cmd.wr     = ffva_pkg::WR_INIT;
        cmd.set_st = 1'b1;
        cmd.st     = ffva_pkg::ST_OK;
      end
      ffva_pkg::S_LOOP: begin
        if (!stat.go) begin
          cmd.set_st = 1'b1;
          cmd.st     = fail_st(stat.op);
        end
      end
      ffva_pkg::S_EVCUR: begin
        cmd.cap = 1'b1;
        if (stat.op == ffva_pkg::REQ_FREE) begin
          if (stat.at_head) begin
            cmd.set_st = 1'b1;
            if (stat.rd_tk) begin
              cmd.wr = ffva_pkg::WR_FREE;
              cmd.st = ffva_pkg::ST_OK;
            end else begin
              cmd.st = ffva_pkg::ST_IGNORED;
            end
          end else if (stat.rd_zero || stat.past_head) begin
            cmd.set_st = 1'b1;
            cmd.st     = ffva_pkg::ST_IGNORED;
          end else begin
            cmd.cur = ffva_pkg::CUR_ADD_RD;
          end
        end else if (stat.rd_zero || stat.rd_over) begin
          cmd.set_st = 1'b1;
          cmd.st     = fail_st(stat.op);
        end else if (stat.rd_tk) begin
          cmd.cur = ffva_pkg::CUR_ADD_RD;
        end else if (stat.op == ffva_pkg::REQ_ALLOC && stat.fit) begin
          if (!stat.split) begin
            cmd.wr      = ffva_pkg::WR_TAKE;
            cmd.set_st  = 1'b1;
            cmd.st      = ffva_pkg::ST_OK;
            cmd.set_off = 1'b1;
          end
        end else if (stat.nxt_end) begin
          if (stat.op == ffva_pkg::REQ_ALLOC) begin
            cmd.set_st = 1'b1;
            cmd.st     = ffva_pkg::ST_NO_SPACE;
          end else begin
            cmd.best = ffva_pkg::BEST_RD;
            cmd.cur  = ffva_pkg::CUR_ADD_RD;
          end
        end else begin
          cmd.rd_nxt = 1'b1;
        end
      end
      ffva_pkg::S_WRSPLIT: cmd.wr = ffva_pkg::WR_SPLIT;
      ffva_pkg::S_WRCUR: begin
        cmd.wr      = ffva_pkg::WR_ALLOC;
        cmd.set_st  = 1'b1;
        cmd.st      = ffva_pkg::ST_OK;
        cmd.set_off = 1'b1;
      end
      ffva_pkg::S_EVNXT: begin
        if (stat.rd_tk) begin
          cmd.cur  = ffva_pkg::CUR_ADD_SZ;
          cmd.best = (stat.op == ffva_pkg::REQ_LARGEST) ? ffva_pkg::BEST_SZ
                                                        : ffva_pkg::BEST_HOLD;
        end else begin
          cmd.wr = ffva_pkg::WR_MERGE;
        end
      end
      ffva_pkg::S_EMIT: cmd.emit = 1'b1;
      default: cmd = '0;
    endcase
  end

  assign busy = (state_r != ffva_pkg::S_IDLE);
endmodule
`default_nettype wire

### rtl/ffva_dp.sv
// Datapath: walk registers, header store access and result registers.
`timescale 1ns / 1ps
`default_nettype none
module ffva_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ffva_pkg::cmd_t                cmd,
  input  wire logic [ffva_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [ffva_pkg::BYTES_W-1:0]  in_size_bytes,
  input  wire logic [ffva_pkg::OFF_W-1:0]    in_free_offset,
  input  wire logic [ffva_pkg::CFG_W-1:0]    cfg_wdata,
  output ffva_pkg::stat_t                    stat,
  output logic                               mem_we,
  output logic [ffva_pkg::ADDR_W-1:0]        mem_waddr,
  output logic [ffva_pkg::HDR_W-1:0]         mem_wdata,
  output logic [ffva_pkg::ADDR_W-1:0]        mem_raddr,
  input  wire logic [ffva_pkg::HDR_W-1:0]    mem_rdata,
  output logic                               out_valid,
  output logic [ffva_pkg::ST_W-1:0]          out_status,
  output logic [ffva_pkg::OFF_W-1:0]         out_payload_offset,
  output logic [ffva_pkg::OFF_W-1:0]         out_largest_bytes
);
  localparam int SW = ffva_pkg::SIZE_W;
  localparam int NW = ffva_pkg::NEED_W;
  localparam int LW = ffva_pkg::LIM_W;

  ffva_pkg::req_t    op_r;
  ffva_pkg::status_t st_r;
  logic [SW-1:0] act_r, cur_r, sz_r, best_r;
  logic [NW-1:0] need_r;
  logic [ffva_pkg::HEAD_W-1:0] head_r;
  logic fbad_r, out_valid_r;
  logic [ffva_pkg::OFF_W-1:0] off_r;

  logic [SW-1:0] rd_sz, cfg_act, best_cand, cur_nxt;
  logic          rd_tk;
  logic [SW:0]   nxt_sum, cp1;
  logic [LW-1:0] lim;
  logic [ffva_pkg::BYTES_W:0] bytes_up;

  assign rd_tk    = mem_rdata[ffva_pkg::HDR_W-1];
  assign rd_sz    = mem_rdata[SW-1:0];
  assign nxt_sum  = (SW+1)'(cur_r) + (SW+1)'(rd_sz);
  assign lim      = LW'(cur_r) + LW'(need_r) + LW'(1);
  assign cp1      = (SW+1)'(cur_r) + (SW+1)'(1);
  assign bytes_up = (ffva_pkg::BYTES_W+1)'(in_size_bytes)
                    + (ffva_pkg::BYTES_W+1)'(ffva_pkg::WORD_BYTES - 1);

  always_comb begin
    if (cfg_wdata > ffva_pkg::CFG_W'(ffva_pkg::HEAP_DEPTH)) begin
      cfg_act = SW'(ffva_pkg::HEAP_DEPTH);
    end else if (cfg_wdata < ffva_pkg::CFG_W'(2)) begin
      cfg_act = '0;
    end else begin
      cfg_act = SW'(cfg_wdata);
    end
  end

  always_comb begin
    stat.op        = op_r;
    stat.rd_tk     = rd_tk;
    stat.rd_zero   = (rd_sz == '0);
    stat.rd_over   = (nxt_sum > (SW+1)'(act_r));
    stat.nxt_end   = (nxt_sum >= (SW+1)'(act_r));
    stat.at_head   = (cur_r == SW'(head_r));
    stat.past_head = (cur_r > SW'(head_r));
    stat.fit       = ((NW'(rd_sz) - NW'(1)) >= need_r);
    stat.split     = ((LW'(need_r) + LW'(3)) <= LW'(rd_sz));
    case (op_r)
      ffva_pkg::REQ_ALLOC:   stat.go = (cur_r < act_r) && (lim <= LW'(act_r));
      ffva_pkg::REQ_FREE:    stat.go = (cur_r < act_r) && !fbad_r;
      ffva_pkg::REQ_LARGEST: stat.go = (cur_r < act_r);
      default:               stat.go = 1'b0;
    endcase
  end

  always_comb begin
    mem_raddr = cmd.rd_nxt ? nxt_sum[ffva_pkg::ADDR_W-1:0] : cur_r[ffva_pkg::ADDR_W-1:0];
    mem_we    = (cmd.wr != ffva_pkg::WR_NONE);
    mem_waddr = cur_r[ffva_pkg::ADDR_W-1:0];
    mem_wdata = '0;
    case (cmd.wr)
      ffva_pkg::WR_INIT: begin
        mem_waddr = '0;
        mem_wdata = {1'b0, act_r};
      end
      ffva_pkg::WR_CFG: begin
        mem_waddr = '0;
        mem_wdata = {1'b0, cfg_act};
      end
      ffva_pkg::WR_SPLIT: begin
        mem_waddr = lim[ffva_pkg::ADDR_W-1:0];
        mem_wdata = {1'b0, SW'(sz_r - SW'(1) - SW'(need_r))};
      end
      ffva_pkg::WR_TAKE:  mem_wdata = {1'b1, rd_sz};
      ffva_pkg::WR_ALLOC: mem_wdata = {1'b1, SW'(need_r + NW'(1))};
      ffva_pkg::WR_FREE:  mem_wdata = {1'b0, rd_sz};
      ffva_pkg::WR_MERGE: mem_wdata = {1'b0, SW'(sz_r + rd_sz)};
      default:            mem_wdata = '0;
    endcase
  end

  always_comb begin
    case (cmd.best)
      ffva_pkg::BEST_RD: best_cand = rd_sz - SW'(1);
      ffva_pkg::BEST_SZ: best_cand = sz_r - SW'(1);
      default:           best_cand = '0;
    endcase
    case (cmd.cur)
      ffva_pkg::CUR_ADD_RD: cur_nxt = SW'(nxt_sum);
      ffva_pkg::CUR_ADD_SZ: cur_nxt = cur_r + sz_r;
      default:              cur_nxt = cur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= SW'(ffva_pkg::HEAP_DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.cfg) begin
        act_r <= cfg_act;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= ffva_pkg::req_t'(in_req_type);
      need_r <= bytes_up[ffva_pkg::BYTES_W:ffva_pkg::WB_SHIFT];
      head_r <= in_free_offset[ffva_pkg::OFF_W-1:ffva_pkg::WB_SHIFT]
                - ffva_pkg::HEAD_W'(1);
      fbad_r <= (in_free_offset == '0)
                || (in_free_offset[ffva_pkg::WB_SHIFT-1:0] != '0);
      cur_r  <= '0;
      off_r  <= '0;
      best_r <= '0;
      st_r   <= ffva_pkg::ST_OK;
    end else begin
      cur_r <= cur_nxt;
      if (cmd.best != ffva_pkg::BEST_HOLD && best_cand > best_r) begin
        best_r <= best_cand;
      end
      if (cmd.set_st) begin
        st_r <= cmd.st;
      end
      if (cmd.set_off) begin
        off_r <= ffva_pkg::OFF_W'({cp1, {ffva_pkg::WB_SHIFT{1'b0}}});
      end
    end
    if (cmd.cap) begin
      sz_r <= rd_sz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = st_r;
  assign out_payload_offset = off_r;
  assign out_largest_bytes  = ffva_pkg::OFF_W'({best_r, {ffva_pkg::WB_SHIFT{1'b0}}});
endmodule
`default_nettype wire

### rtl/first_fit_variable_allocator_unit.sv
// Top level of the first-fit heap allocator with deferred coalescing.
//
// Requests enter on in_* with start; one is taken when start is high and
// busy is low. Types: alloc (size in bytes), free (payload byte offset),
// largest free payload, and reinitialize. Every request yields exactly one
// result: out_valid pulses for one cycle with out_status, out_payload_offset
// and out_largest_bytes. The receiver cannot stall; results are not held.
// Block headers live in a 1024 x 12 RAM with a registered read port and are
// walked one header at a time: each header visited passes through the loop
// and evaluate states, a free block's successor is read in a further state
// (a merge then re-reads the merged header), and a split writes the split
// header, then the allocated one. Busy drops with the result strobe, so the
// next request can be taken in the strobe cycle. A request with nothing to
// walk goes from the loop state straight to the result; a reinitialize
// rewrites the heap as one free block. While idle, cfg_we with cfg_wdata
// sets heap_words (clamped to 1024, below 2 = empty) and rewrites the heap
// as one free block in the same cycle. After reset the heap is 1024 words,
// one free block; busy stays high for one cycle while that header is written.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_variable_allocator_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ffva_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic [ffva_pkg::BYTES_W-1:0] in_size_bytes,
  input  wire logic [ffva_pkg::OFF_W-1:0]   in_free_offset,
  output logic                              out_valid,
  output logic [ffva_pkg::ST_W-1:0]         out_status,
  output logic [ffva_pkg::OFF_W-1:0]        out_payload_offset,
  output logic [ffva_pkg::OFF_W-1:0]        out_largest_bytes,
  input  wire logic                         cfg_we,
  input  wire logic [ffva_pkg::CFG_W-1:0]   cfg_wdata
);
  ffva_pkg::cmd_t  cmd;
  ffva_pkg::stat_t stat;
  logic                        mem_we;
  logic [ffva_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [ffva_pkg::HDR_W-1:0]  mem_wdata, mem_rdata;

  ffva_ram #(
    .W(ffva_pkg::HDR_W),
    .D(ffva_pkg::HEAP_DEPTH)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  ffva_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .req   (ffva_pkg::req_t'(in_req_type)),
    .cfg_we(cfg_we),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ffva_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_req_type       (in_req_type),
    .in_size_bytes     (in_size_bytes),
    .in_free_offset    (in_free_offset),
    .cfg_wdata         (cfg_wdata),
    .stat              (stat),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_payload_offset(out_payload_offset),
    .out_largest_bytes (out_largest_bytes)
  );

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in flight");

  a_offset_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload_offset != '0)
      |-> out_status == ffva_pkg::ST_OK)
    else $error("offset reported on failed request");

  a_largest_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_largest_bytes != '0)
      |-> (out_status == ffva_pkg::ST_OK && out_payload_offset == '0))
    else $error("largest reported with bad status or offset");
endmodule
`default_nettype wire
